@@ hdl/b64d_pkg.sv @@
// ----------------------------------------------------------------------------
// b64d_pkg
// Shared types, constants and the alphabet lookup of the base64 decoder.
// ----------------------------------------------------------------------------
package b64d_pkg;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_PADDING = 2'd2,
		ST_LENGTH  = 2'd3
	} status_t;

	localparam logic [7:0] PAD_CHAR       = 8'h3D;
	localparam logic [6:0] SEXTET_INVALID = 7'd64;

	// Result queue geometry.
	localparam int QDEPTH = 4;
	localparam int QAW    = $clog2(QDEPTH);
	localparam int QCW    = $clog2(QDEPTH + 1);

	// One decoded group (or one error) as it waits to be sent out word by word.
	typedef struct packed {
		logic [23:0] bits;
		logic [1:0]  nbytes;
		logic        is_final;
		status_t     status;
	} pkt_t;

	// Map a character to its 6-bit value; bit 6 set marks a byte outside the alphabet.
	function automatic logic [6:0] sextet_of(input logic [7:0] c);
		logic [6:0] v;
		v = SEXTET_INVALID;
		if (c >= 8'h41 && c <= 8'h5A) begin
			v = 7'(c - 8'd65);
		end else if (c >= 8'h61 && c <= 8'h7A) begin
			v = 7'(c - 8'd71);
		end else if (c >= 8'h30 && c <= 8'h39) begin
			v = 7'(c + 8'd4);
		end else if (c == 8'h2B) begin
			v = 7'd62;
		end else if (c == 8'h2F) begin
			v = 7'd63;
		end else if (c == PAD_CHAR) begin
			v = 7'd0;
		end
		return v;
	endfunction

endpackage

@@ hdl/b64d_decode.sv @@
// ----------------------------------------------------------------------------
// b64d_decode
// Input register, group state and the single-pass decode of one character.
// ----------------------------------------------------------------------------
module b64d_decode (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic [7:0]     character,
	input  logic           final_char,
	input  logic           q_full,
	output logic           push,
	output b64d_pkg::pkt_t pkt
);
	import b64d_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        final_s1;

	logic [23:0] bits_q;
	logic [1:0]  pos_q;
	logic [1:0]  pad_q;
	logic        skip_q;

	logic [23:0] nxt_bits;
	logic [1:0]  nxt_pos;
	logic [1:0]  nxt_pad;
	logic        nxt_skip;

	logic        fire;
	logic        accept;
	logic [6:0]  sext;
	logic        is_pad;
	logic [23:0] shifted;
	logic [2:0]  pads;
	logic        err;
	logic        emit;
	status_t     err_st;

	assign fire     = valid_s1 && !q_full;
	assign in_stall = valid_s1 && q_full;
	assign accept   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			char_s1  <= character;
			final_s1 <= final_char;
		end
	end

	assign sext    = sextet_of(char_s1);
	assign is_pad  = (char_s1 == PAD_CHAR);
	assign shifted = {bits_q[17:0], sext[5:0]};
	assign pads    = {1'b0, pad_q} + {2'b00, is_pad};

	always_comb begin
		nxt_bits = bits_q;
		nxt_pos  = pos_q;
		nxt_pad  = pad_q;
		nxt_skip = skip_q;
		err      = 1'b0;
		emit     = 1'b0;
		err_st   = ST_OK;
		if (skip_q) begin
			// Dropping after an error: only the final character matters.
			if (final_s1) begin
				nxt_skip = 1'b0;
			end
		end else if (final_s1 && pos_q != 2'd3) begin
			err    = 1'b1;
			err_st = ST_LENGTH;
		end else if (sext[6]) begin
			err    = 1'b1;
			err_st = ST_INVALID;
		end else if (pad_q != 2'd0 && !is_pad) begin
			err    = 1'b1;
			err_st = ST_PADDING;
		end else if (pos_q != 2'd3) begin
			nxt_bits = shifted;
			nxt_pos  = pos_q + 2'd1;
			nxt_pad  = pads[1:0];
		end else if (pads > 3'd2 || (pads != 3'd0 && !final_s1)) begin
			err    = 1'b1;
			err_st = ST_PADDING;
		end else begin
			emit     = 1'b1;
			nxt_bits = '0;
			nxt_pos  = 2'd0;
			nxt_pad  = 2'd0;
		end
		if (err) begin
			nxt_bits = '0;
			nxt_pos  = 2'd0;
			nxt_pad  = 2'd0;
			nxt_skip = !final_s1;
		end
	end

	always_comb begin
		push         = fire && (err || emit);
		pkt.bits     = emit ? shifted : 24'd0;
		pkt.nbytes   = err ? 2'd1 : 2'(3'd3 - pads);
		pkt.is_final = final_s1;
		pkt.status   = err_st;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_q <= '0;
			pos_q  <= 2'd0;
			pad_q  <= 2'd0;
			skip_q <= 1'b0;
		end else if (fire) begin
			bits_q <= nxt_bits;
			pos_q  <= nxt_pos;
			pad_q  <= nxt_pad;
			skip_q <= nxt_skip;
		end
	end

`ifndef SYNTH
	a_skip_clean: assert property (@(posedge clk) disable iff (!arst_n)
		skip_q |-> (pos_q == 2'd0 && pad_q == 2'd0))
		else $error("group state not cleared while dropping input");
	a_pad_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(pad_q != 2'd0) |-> (pos_q != 2'd0))
		else $error("padding counted at the start of a group");
	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (!q_full && valid_s1))
		else $error("result pushed without room in the queue");
`endif

endmodule

@@ hdl/b64d_out_queue.sv @@
// ----------------------------------------------------------------------------
// b64d_out_queue
// Queue of decoded groups and the serialiser that sends them out a word
// at a time.
// ----------------------------------------------------------------------------
module b64d_out_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  b64d_pkg::pkt_t pkt,
	output logic           q_full,
	output logic           out_valid,
	input  logic           out_stall,
	output logic [7:0]     data_byte,
	output logic           group_last,
	output logic           stream_end,
	output logic [1:0]     status
);
	import b64d_pkg::*;

	pkt_t             mem_q [QDEPTH];
	logic [QAW-1:0]   wr_ptr_q;
	logic [QAW-1:0]   rd_ptr_q;
	logic [QCW-1:0]   count_q;
	logic [1:0]       idx_q;

	pkt_t             head;
	logic             last;
	logic             pop;
	logic             send;

	assign head      = mem_q[rd_ptr_q];
	assign q_full    = (count_q == QCW'(QDEPTH));
	assign out_valid = (count_q != '0);
	assign send      = out_valid && !out_stall;
	assign last      = (idx_q == head.nbytes - 2'd1);
	assign pop       = send && last;

	always_comb begin
		case (idx_q)
			2'd0:    data_byte = head.bits[23:16];
			2'd1:    data_byte = head.bits[15:8];
			default: data_byte = head.bits[7:0];
		endcase
	end

	assign group_last = last;
	assign stream_end = last && head.is_final;
	assign status     = head.status;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
			idx_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QAW'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QAW'(1);
				idx_q    <= 2'd0;
			end else if (send) begin
				idx_q <= idx_q + 2'd1;
			end
			if (push && !pop) begin
				count_q <= count_q + QCW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - QCW'(1);
			end
		end
	end

`ifndef SYNTH
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= QCW'(QDEPTH))
		else $error("result queue overfilled");
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (idx_q < head.nbytes))
		else $error("word index beyond the bytes of its group");
	a_idx_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> (idx_q == 2'd0))
		else $error("word index left over with an empty queue");
`endif

endmodule

@@ hdl/base64_decoder.sv @@
// ----------------------------------------------------------------------------
// base64_decoder
// Streaming base64 decoder, standard alphabet with '=' padding.
// ----------------------------------------------------------------------------
// One encoded character is taken per cycle, with final_char on the last one
// of a string. Every fourth character releases a group of up to three decoded
// bytes, each sent as one word on the output side; an error gives a single
// word with a non-zero status and zero data, after which characters are
// dropped up to the final one. A character is registered, decoded in one
// pass against the group state, and its words are written into a four-entry
// group queue when it has room. The input stalls only while that queue is full,
// which happens only when the output side is stalled, so with a free-running
// receiver one character is accepted every cycle.
module base64_decoder (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] character,
	input  logic       final_char,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] data_byte,
	output logic       group_last,
	output logic       stream_end,
	output logic [1:0] status
);
	import b64d_pkg::*;

	logic q_full;
	logic push;
	pkt_t pkt;

	b64d_decode u_decode (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.character  (character),
		.final_char (final_char),
		.q_full     (q_full),
		.push       (push),
		.pkt        (pkt)
	);

	b64d_out_queue u_out_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.pkt        (pkt),
		.q_full     (q_full),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.group_last (group_last),
		.stream_end (stream_end),
		.status     (status)
	);

endmodule

@@ tb/sv/base64_decoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base64_decoder_test
// Self-checking testbench for the streaming base64 decoder.
// ----------------------------------------------------------------------------
// A queue of characters is built up front: a handful of hand-picked strings
// that hit each error path, then random strings that are mostly well formed,
// with some corrupted, cut short or replaced by noise. A clocked driver offers
// them with random gaps, and a second process stalls the output in random
// bursts and once for a long stretch. Every accepted character is decoded by
// a local model of the group logic, and each output word is checked against
// the oldest decoded word still outstanding.
// ----------------------------------------------------------------------------
module base64_decoder_test;
	import b64d_pkg::*;

	localparam string ALPHABET =
		"ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
	localparam int RANDOM_CHARS = 230;
	localparam int TAIL_CHARS   = 40;

	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic       drain;
	} char_item_t;

	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       send;
		status_t    st;
	} decoded_word_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid   = 1'b0;
	logic       in_stall;
	logic [7:0] character  = 8'd0;
	logic       final_char = 1'b0;
	logic       out_valid;
	logic       out_stall  = 1'b0;
	logic [7:0] data_byte;
	logic       group_last;
	logic       stream_end;
	logic [1:0] status;

	base64_decoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.character  (character),
		.final_char (final_char),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.data_byte  (data_byte),
		.group_last (group_last),
		.stream_end (stream_end),
		.status     (status)
	);

	char_item_t    char_q[$];
	decoded_word_t expected_words[$];
	decoded_word_t want;
	logic [6:0]    sextet_lut [256];

	// Decoder state as the block should hold it.
	logic [23:0] grp_bits;
	logic [1:0]  char_pos;
	logic [1:0]  pad_cnt;
	logic        dropping;

	int chars_taken = 0;
	int words_seen  = 0;
	int mismatches  = 0;
	int gap_left    = 0;
	int run_left    = 0;
	int hold_left   = 0;
	bit hold_done   = 0;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic void clear_group(logic skip);
		grp_bits = '0;
		char_pos = '0;
		pad_cnt  = '0;
		dropping = skip;
	endfunction

	function automatic void add_expected(decoded_word_t w);
		expected_words.insert(expected_words.size(), w);
	endfunction

	function automatic void expect_error(status_t st, logic fin);
		add_expected('{data: 8'd0, last: 1'b1, send: fin, st: st});
		clear_group(!fin);
	endfunction

	function automatic void decode_char(logic [7:0] c, logic fin);
		logic [6:0] v;
		logic [2:0] pads;
		int         nbytes;
		if (dropping) begin
			if (fin)
				clear_group(1'b0);
			return;
		end
		// Unless dropping, the length check outranks every other check on a final character.
		if (fin && char_pos != 2'd3) begin
			expect_error(ST_LENGTH, 1'b1);
			return;
		end
		v = sextet_lut[c];
		if (v[6]) begin
			expect_error(ST_INVALID, fin);
			return;
		end
		if (pad_cnt != 2'd0 && c != PAD_CHAR) begin
			expect_error(ST_PADDING, fin);
			return;
		end
		grp_bits = {grp_bits[17:0], v[5:0]};
		pads = {1'b0, pad_cnt} + 3'(c == PAD_CHAR);
		if (char_pos != 2'd3) begin
			char_pos = char_pos + 2'd1;
			pad_cnt  = pads[1:0];
			return;
		end
		if (pads > 3'd2 || (pads != 3'd0 && !fin)) begin
			expect_error(ST_PADDING, fin);
			return;
		end
		nbytes = 3 - int'(pads);
		for (int i = 0; i < nbytes; i++) begin
			add_expected('{data: grp_bits[23 - 8 * i -: 8],
				last: (i == nbytes - 1), send: fin && (i == nbytes - 1), st: ST_OK});
		end
		clear_group(1'b0);
	endfunction

	task automatic put_char(logic [7:0] c, logic fin, logic drain);
		char_item_t it;
		it = '{ch: c, fin: fin, drain: drain};
		char_q.insert(char_q.size(), it);
	endtask

	task automatic put_text(string s, logic fin);
		for (int i = 0; i < s.len(); i++)
			put_char(s[i], fin && (i == s.len() - 1), 1'b0);
	endtask

	// One random string: mostly valid, sometimes damaged in one of a few ways.
	task automatic add_string(logic drain_first);
		logic [7:0] s[$];
		int         groups;
		int         pads;
		int         kind;
		int         cut;
		groups = ($urandom_range(0, 9) == 0) ? $urandom_range(4, 8) : $urandom_range(1, 3);
		for (int i = 0; i < groups * 4; i++)
			s.insert(s.size(), ALPHABET[$urandom_range(0, 63)]);
		pads = $urandom_range(0, 2);
		for (int i = 0; i < pads; i++)
			s[s.size() - 1 - i] = PAD_CHAR;
		kind = $urandom_range(0, 11);
		if (kind == 0) begin
			s[$urandom_range(0, s.size() - 1)] = 8'($urandom_range(0, 255));
		end else if (kind == 1) begin
			s[$urandom_range(0, s.size() - 1)] = PAD_CHAR;
		end else if (kind == 2) begin
			cut = $urandom_range(1, 3);
			for (int i = 0; i < cut; i++)
				void'(s.pop_back());
		end else if (kind == 3) begin
			// Noise: random bytes with the final flag at random spots.
			s.delete();
			cut = $urandom_range(1, 8);
			for (int i = 0; i < cut; i++)
				s.insert(s.size(), 8'($urandom_range(0, 255)));
			for (int i = 0; i < cut - 1; i++)
				put_char(s[i], ($urandom_range(0, 5) == 0), drain_first && i == 0);
			put_char(s[cut - 1], 1'b1, drain_first && cut == 1);
			return;
		end
		for (int i = 0; i < s.size(); i++)
			put_char(s[i], i == s.size() - 1, drain_first && i == 0);
	endtask

	// Sender: one character per accepted transfer, with random gaps.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid   <= 1'b0;
			character  <= 8'd0;
			final_char <= 1'b0;
			gap_left   <= 0;
		end else if (!in_valid || !in_stall) begin
			if (in_valid) begin
				decode_char(character, final_char);
				chars_taken++;
			end
			if (gap_left != 0) begin
				gap_left <= gap_left - 1;
				in_valid <= 1'b0;
			end else if (char_q.size() == 0
					|| (char_q[0].drain && expected_words.size() != 0)) begin
				in_valid <= 1'b0;
			end else if (char_q.size() > TAIL_CHARS && (chars_taken / 40) % 3 != 1
					&& $urandom_range(0, 7) == 0) begin
				gap_left <= $urandom_range(0, 18);
				in_valid <= 1'b0;
			end else begin
				character  <= char_q[0].ch;
				final_char <= char_q[0].fin;
				in_valid   <= 1'b1;
				void'(char_q.pop_front());
			end
		end
	end

	// Receiver stall: one long hold to back the block up, otherwise random runs.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			run_left  <= 0;
			hold_left <= 0;
			hold_done <= 0;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
			out_stall <= (hold_left != 1);
		end else if (!hold_done && chars_taken >= 70) begin
			hold_done <= 1;
			hold_left <= 120;
			out_stall <= 1'b1;
		end else if (run_left == 0) begin
			run_left  <= $urandom_range(0, 18);
			out_stall <= char_q.size() > TAIL_CHARS && (words_seen / 30) % 3 != 2
				&& $urandom_range(0, 2) == 0;
		end else begin
			run_left <= run_left - 1;
			if (char_q.size() <= TAIL_CHARS)
				out_stall <= 1'b0;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			words_seen++;
			if (expected_words.size() == 0) begin
				if (mismatches < 10)
					$display("%0t: unexpected word data=%02h last=%0b end=%0b status=%0d",
						$realtime, data_byte, group_last, stream_end, status);
				mismatches++;
			end else begin
				want = expected_words.pop_front();
				if (data_byte !== want.data || group_last !== want.last
						|| stream_end !== want.send || status !== want.st) begin
					if (mismatches < 10)
						$display({"%0t: word mismatch expected data=%02h last=%0b end=%0b ",
							"status=%0d, got data=%02h last=%0b end=%0b status=%0d"},
							$realtime, want.data, want.last, want.send, want.st,
							data_byte, group_last, stream_end, status);
					mismatches++;
				end
			end
		end
	end

	initial begin
		int n_strings;
		int directed_n;
		for (int i = 0; i < 256; i++)
			sextet_lut[i] = 7'd64;
		for (int i = 0; i < 64; i++)
			sextet_lut[ALPHABET[i]] = 7'(i);
		sextet_lut[PAD_CHAR] = 7'd0;
		clear_group(1'b0);

		// Hand-picked strings: alphabet extremes with double padding, a short
		// string, data after padding, too much padding, padding in a middle
		// group, an invalid final character, and out-of-range bytes.
		put_text("A/+9z0==", 1'b1);
		put_text("ab", 1'b1);
		put_text("A=Bx", 1'b1);
		put_text("A===", 1'b1);
		put_text("AB==C", 1'b1);
		put_text("AAA", 1'b0);
		put_char(8'h80, 1'b1, 1'b0);
		put_text("Q", 1'b0);
		put_char(8'hFF, 1'b0, 1'b0);
		put_char(8'h00, 1'b1, 1'b0);
		directed_n = char_q.size();

		n_strings = 0;
		while (char_q.size() < directed_n + RANDOM_CHARS) begin
			add_string(n_strings == 6 || n_strings == 40);
			n_strings++;
		end

		arst_n = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (char_q.size() != 0 || in_valid || expected_words.size() != 0)
			@(posedge clk);
		repeat (30) @(posedge clk);
		if (mismatches == 0 && expected_words.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin
		#3_000_000;
		$display("simulation failed");
		$finish;
	end

endmodule

@@ files.f @@
hdl/b64d_pkg.sv
hdl/b64d_decode.sv
hdl/b64d_out_queue.sv
hdl/base64_decoder.sv
tb/sv/base64_decoder_test.sv
